// ===== rtl/sine_oscillator_core_macros.svh =====
// assertion macros shared by the sine oscillator checker
// no dependencies; included by the checker file only
`ifndef SINE_OSCILLATOR_CORE_MACROS_SVH
`define SINE_OSCILLATOR_CORE_MACROS_SVH

// property checked on the rising clock, off while reset is low
`define SOSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on the rising clock, also during reset
`define SOSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/sosc_pkg.sv =====
// shared types and constants of the sine oscillator
// no dependencies; used by every module of the block
package sosc_pkg;

    // rotation datapath width, holds x, y and z with headroom
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_GAIN_INIT = 652032874;
    // z uses 2^30 for a quarter cycle
    localparam int Z_FRAC_BITS  = 30;

    // atan(2^-i) as a fraction of a cycle times 2^32
    localparam logic [31:0] ATAN_STEPS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21352417,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1
    };

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_AMPLITUDE   = 2'd0,
        REG_PHASE_INC   = 2'd1,
        REG_PHASE_OFF   = 2'd2
    } t_reg_idx;

    // rotation state handed from cell to cell
    typedef struct packed {
        logic [CORDIC_W-1:0] x;
        logic [CORDIC_W-1:0] y;
        logic [CORDIC_W-1:0] z;
        logic                neg;
    } t_cordic;

endpackage

// ===== rtl/sosc_stream_if.sv =====
// valid/ready channels for sample indexes in and sample values out
// no dependencies
interface sosc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

interface sosc_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

// ===== rtl/sine_oscillator_core.sv =====
// Sine oscillator evaluated at an absolute sample index. Each item passes
// through registered phase math (32x32 multiply, then offset add and
// quadrant fold), the chain of rotation cells, one per step, and registered
// gain, then rounding and saturation. One item is accepted every cycle; a
// stall at the output holds the chain, and empty slots in the chain fill up
// before the input side stalls. Configuration is a small APB-style register
// file at byte addresses 0, 4 and 8, with no reset pass and no wait states.
module sine_oscillator_core #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sosc_in_if.sink           i_sample,
    sosc_out_if.source        o_sample,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int STEPS = sosc_pkg::CORDIC_STEPS;

    logic [15:0]          r_amp;
    logic [31:0]          r_inc;
    logic [31:0]          r_off;
    logic                 w_write;
    sosc_pkg::t_reg_idx   w_idx;

    sosc_pkg::t_cordic    w_c     [STEPS+1];
    logic                 w_valid [STEPS+1];
    logic                 w_ready [STEPS+1];
    logic                 w_scale_ready;

    // register file
    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_idx   = sosc_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= 16'd32768;
            r_inc <= 32'd42852281;
            r_off <= 32'd0;
        end else if (w_write) begin
            unique case (w_idx)
                sosc_pkg::REG_AMPLITUDE: r_amp <= pwdata[15:0];
                sosc_pkg::REG_PHASE_INC: r_inc <= pwdata;
                sosc_pkg::REG_PHASE_OFF: r_off <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            sosc_pkg::REG_AMPLITUDE: prdata = {16'd0, r_amp};
            sosc_pkg::REG_PHASE_INC: prdata = r_inc;
            sosc_pkg::REG_PHASE_OFF: prdata = r_off;
            default:                 prdata = 32'd0;
        endcase
    end

    // phase and fold
    sosc_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_sample.valid),
        .o_ready  (i_sample.ready),
        .i_index  (i_sample.sample_index),
        .i_inc    (r_inc),
        .i_offset (r_off),
        .o_valid  (w_valid[0]),
        .i_ready  (w_ready[0]),
        .o_c      (w_c[0])
    );

    // rotation chain
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        sosc_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_c     (w_c[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_c     (w_c[g+1])
        );
    end

    assign w_ready[STEPS] = w_scale_ready;

    // gain and output
    sosc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[STEPS]),
        .o_ready (w_scale_ready),
        .i_c     (w_c[STEPS]),
        .i_amp   (r_amp),
        .o_valid (o_sample.valid),
        .i_ready (o_sample.ready),
        .o_value (o_sample.sample_value)
    );

endmodule

// ===== rtl/sosc_phase.sv =====
// phase from index times increment plus offset, and quadrant folding ahead of the rotation chain
// depends on sosc_pkg
module sosc_phase #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_index,
    input  logic [31:0]          i_inc,
    input  logic [31:0]          i_offset,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sosc_pkg::t_cordic    o_c
);

    localparam int CW = sosc_pkg::CORDIC_W;
    localparam int QB = TABLE_ADDR_BITS + 2;

    logic                     r_prod_valid;
    logic [63:0]              r_prod;
    logic                     r_fold_valid;
    sosc_pkg::t_cordic        r_c;
    sosc_pkg::t_cordic        n_c;
    logic                     w_prod_load;
    logic                     w_fold_load;
    logic [63:0]              w_sum;
    logic [PHASE_BITS-1:0]    w_phase;
    logic [QB-1:0]            w_q;
    logic [TABLE_ADDR_BITS-1:0] w_k;
    logic [TABLE_ADDR_BITS:0] w_j;

    assign w_fold_load = !r_fold_valid || i_ready;
    assign w_prod_load = !r_prod_valid || w_fold_load;
    assign o_ready     = w_prod_load;

    // fold the phase into a step of the quarter wave
    always_comb begin
        w_sum   = r_prod + {32'd0, i_offset};
        w_phase = w_sum[PHASE_BITS-1:0];
        w_q     = w_phase[PHASE_BITS-1 -: QB];
        w_k     = w_q[TABLE_ADDR_BITS-1:0];
        if (w_q[TABLE_ADDR_BITS]) begin
            w_j = {1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, w_k};
        end else begin
            w_j = {1'b0, w_k};
        end
        n_c.x   = CW'(sosc_pkg::CORDIC_GAIN_INIT);
        n_c.y   = '0;
        n_c.z   = {{(CW - sosc_pkg::Z_FRAC_BITS - 1){1'b0}}, w_j,
                   {(sosc_pkg::Z_FRAC_BITS - TABLE_ADDR_BITS){1'b0}}};
        n_c.neg = w_q[TABLE_ADDR_BITS+1];
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_fold_valid <= 1'b0;
        end else begin
            if (w_prod_load) r_prod_valid <= i_valid;
            if (w_fold_load) r_fold_valid <= r_prod_valid;
        end
    end

    // index times increment, then folded phase
    always_ff @(posedge i_clk) begin
        if (w_prod_load && i_valid) r_prod <= i_index * i_inc;
        if (w_fold_load && r_prod_valid) r_c <= n_c;
    end

    assign o_valid = r_fold_valid;
    assign o_c     = r_c;

endmodule

// ===== rtl/sosc_cordic_cell.sv =====
// one rotation step of the sine chain, shift amount fixed per cell
// depends on sosc_pkg
module sosc_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sosc_pkg::t_cordic i_c,
    output logic              o_valid,
    input  logic              i_ready,
    output sosc_pkg::t_cordic o_c
);

    localparam int CW = sosc_pkg::CORDIC_W;
    localparam logic signed [CW-1:0] ANGLE = CW'(sosc_pkg::ATAN_STEPS[STEP]);

    logic                 r_valid;
    sosc_pkg::t_cordic    r_c;
    sosc_pkg::t_cordic    n_c;
    logic                 w_load;
    logic signed [CW-1:0] w_x;
    logic signed [CW-1:0] w_y;
    logic signed [CW-1:0] w_z;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;

    // rotate toward zero residual angle
    always_comb begin
        w_x  = $signed(i_c.x);
        w_y  = $signed(i_c.y);
        w_z  = $signed(i_c.z);
        w_dx = w_y >>> STEP;
        w_dy = w_x >>> STEP;
        n_c.neg = i_c.neg;
        if (!w_z[CW-1]) begin
            n_c.x = w_x - w_dx;
            n_c.y = w_y + w_dy;
            n_c.z = w_z - ANGLE;
        end else begin
            n_c.x = w_x + w_dx;
            n_c.y = w_y - w_dy;
            n_c.z = w_z + ANGLE;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    // rotation state
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) r_c <= n_c;
    end

    assign o_valid = r_valid;
    assign o_c     = r_c;

endmodule

// ===== rtl/sosc_scale.sv =====
// amplitude gain, rounding, saturation and output register
// depends on sosc_pkg
module sosc_scale #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  sosc_pkg::t_cordic             i_c,
    input  logic [15:0]                   i_amp,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_value
);

    localparam int CW = sosc_pkg::CORDIC_W;
    localparam int PW = CW + 17;
    localparam int SH = 46 - SAMPLE_BITS;
    localparam logic [PW-1:0] HALF     = PW'(64'd1 << (SH - 1));
    localparam logic [PW-1:0] HALF_NEG = PW'((64'd1 << (SH - 1)) + 64'd1);
    localparam logic signed [PW-1:0] MAX_OUT = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] MIN_OUT = -MAX_OUT - PW'(1);

    logic                          r_mul_valid;
    logic signed [PW-1:0]          r_prod;
    logic                          r_neg;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_value;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic                          w_mul_load;
    logic                          w_out_load;
    logic [PW-1:0]                 w_sum;
    logic signed [PW-1:0]          w_shift;

    assign w_out_load = !r_out_valid || i_ready;
    assign w_mul_load = !r_mul_valid || w_out_load;
    assign o_ready    = w_mul_load;

    // negate folded into the rounding add: -p + h = ~p + h + 1
    always_comb begin
        if (r_neg) begin
            w_sum = ~r_prod + HALF_NEG;
        end else begin
            w_sum = r_prod + HALF;
        end
        w_shift = $signed(w_sum) >>> SH;
        if (w_shift > MAX_OUT) begin
            n_value = MAX_OUT[SAMPLE_BITS-1:0];
        end else if (w_shift < MIN_OUT) begin
            n_value = MIN_OUT[SAMPLE_BITS-1:0];
        end else begin
            n_value = w_shift[SAMPLE_BITS-1:0];
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_mul_load) r_mul_valid <= i_valid;
            if (w_out_load) r_out_valid <= r_mul_valid;
        end
    end

    // gain product, then rounded sample
    always_ff @(posedge i_clk) begin
        if (w_mul_load && i_valid) begin
            r_prod <= $signed(i_c.y) * $signed({1'b0, i_amp});
            r_neg  <= i_c.neg;
        end
        if (w_out_load && r_mul_valid) r_value <= n_value;
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;

endmodule

// ===== rtl/sosc_checker.sv =====
// port-level checks for the sine oscillator, bound to the top level
// depends on sine_oscillator_core_macros.svh, sosc_pkg and sine_oscillator_core
`include "sine_oscillator_core_macros.svh"

module sosc_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_value,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [3:0]             paddr,
    input logic [31:0]            pwdata,
    input logic [31:0]            prdata,
    input logic                   pready
);

    logic [1:0]  w_idx;
    logic        w_wr;
    logic [31:0] w_wr_val;

    // register slot of a write and the value it should read back as
    assign w_idx    = paddr[3:2];
    assign w_wr     = psel && penable && pwrite && pready
                      && (w_idx <= sosc_pkg::REG_PHASE_OFF);
    assign w_wr_val = (w_idx == sosc_pkg::REG_AMPLITUDE) ? {16'd0, pwdata[15:0]}
                                                         : pwdata;

    // the pipeline comes out of reset empty
    `SOSC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid,
        "result after reset")

    // a written register reads back at the same address
    `SOSC_ASSERT(a_readback, i_clk, i_rst_n,
        w_wr |=> (w_idx != $past(w_idx) || prdata == $past(w_wr_val)),
        "register readback mismatch")

    // a stalled result stays offered
    `SOSC_ASSERT(a_valid_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> i_out_valid,
        "result dropped under stall")

    // a stalled result keeps its value
    `SOSC_ASSERT(a_value_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> $stable(i_out_value),
        "result changed under stall")

endmodule

bind sine_oscillator_core sosc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sosc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_sample.valid),
    .i_out_ready (o_sample.ready),
    .i_out_value (o_sample.sample_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

// ===== bench/sine_oscillator_core_tb.sv =====
// self-checking testbench for the sine oscillator core
// depends on sosc_pkg, the stream interfaces and sine_oscillator_core
module sine_oscillator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_W     = 32;
    localparam int TAB_BITS    = 10;
    localparam int TAB_STEPS   = 1 << TAB_BITS;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_SHIFT  = 46 - SAMPLE_W;
    localparam int ROT_STEPS   = 30;
    localparam longint ROT_GAIN_START = 652032874;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 40;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // register slot past the last real one, writes there do nothing
    localparam logic [2:0] REG_UNUSED = 3'd3;
    localparam logic [2:0] REG_NONE   = 3'd7;

    // rotation angles atan(2^-i), cycles times 2^32
    localparam longint ROT_ANGLE [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21352417,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1
    };

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_CHECK,
        ROW_PREDICT
    } t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [2:0]                  reg_idx;
        logic [31:0]                 val;
        logic signed [SAMPLE_W-1:0]  want;
    } t_dir_row;

    typedef struct {
        logic [31:0]                 idx;
        logic signed [SAMPLE_W-1:0]  value;
    } t_pending;

    // directed items: read-off values where obvious, predictor elsewhere
    localparam int N_DIRECTED = 43;
    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_CHECK,   REG_NONE,                32'h0000_0000, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_0001, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_0064, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'hffff_ffff, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_INC, 32'h0000_0000, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h4000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'hffff_ffff, SAMPLE_MAX},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h400f_ffff, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'h1234_5678, SAMPLE_MAX},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'hc000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'h0000_0005, SAMPLE_MIN},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h8000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'h0000_0000, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_AMPLITUDE, 32'h0000_4000, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h4000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'haaaa_aaaa, 16'sd16384},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'hc000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'h5555_5555, -16'sd16384},
        '{ROW_WRITE,   sosc_pkg::REG_AMPLITUDE, 32'h0000_ffff, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'h0000_0000, SAMPLE_MIN},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h4000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'h0000_0000, SAMPLE_MAX},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h2000_0000, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_0007, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_AMPLITUDE, 32'h0000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'hffff_ffff, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_AMPLITUDE, 32'h0000_8000, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h4000_0000, 16'sd0},
        '{ROW_WRITE,   REG_UNUSED,              32'h0000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'h0000_0000, SAMPLE_MAX},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_INC, 32'h0000_0001, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h0000_0001, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'hffff_ffff, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_INC, 32'hffff_ffff, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_OFF, 32'h0000_0000, 16'sd0},
        '{ROW_CHECK,   REG_NONE,                32'hffff_ffff, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_0001, 16'sd0},
        '{ROW_WRITE,   sosc_pkg::REG_PHASE_INC, 32'h0010_0000, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_03ff, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_0400, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_07ff, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_0c00, 16'sd0},
        '{ROW_PREDICT, REG_NONE,                32'h0000_0fff, 16'sd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sosc_in_if                          index_ch ();
    sosc_out_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();

    sine_oscillator_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (index_ch),
        .o_sample (sample_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the gain and phase registers
    logic [15:0] osc_amplitude;
    logic [31:0] osc_phase_inc;
    logic [31:0] osc_phase_off;

    // quarter-wave sine, Q2.30, entries 0 .. TAB_STEPS
    longint quarter_wave [0:TAB_STEPS];

    t_pending pending_samples [$];
    t_pending oldest_sample;

    int error_count;
    int cycle_count;
    int src_idle_pct;
    int snk_stall_pct;
    int rx_hold_left;

    // integer rotation, floor shifts, gives sine of j/TAB_STEPS quarter cycles
    function automatic longint rotate_quarter_sine(input int j);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = ROT_GAIN_START;
        y = 0;
        z = longint'(j) << (30 - TAB_BITS);
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ROT_ANGLE[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ROT_ANGLE[i];
            end
        end
        return y;
    endfunction

    // phase from index, quadrant fold, gain, rounding and saturation
    function automatic logic signed [SAMPLE_W-1:0] predict_sample(input logic [31:0] idx);
        logic [PHASE_W-1:0]  phase;
        logic [1:0]          quad;
        logic [TAB_BITS-1:0] step;
        longint              sine;
        longint              prod;
        longint              v;
        phase = idx * osc_phase_inc + osc_phase_off;
        quad  = phase[PHASE_W-1 -: 2];
        step  = phase[PHASE_W-3 -: TAB_BITS];
        if (quad[0]) begin
            sine = quarter_wave[TAB_STEPS - int'(step)];
        end else begin
            sine = quarter_wave[step];
        end
        if (quad[1]) begin
            sine = -sine;
        end
        prod = sine * longint'({48'd0, osc_amplitude});
        v = (prod + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
        if (v > longint'(SAMPLE_MAX)) begin
            v = longint'(SAMPLE_MAX);
        end
        if (v < longint'(SAMPLE_MIN)) begin
            v = longint'(SAMPLE_MIN);
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // sample side: compare each item against the oldest pending one, then drive ready
    always @(posedge i_clk) begin
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            if (pending_samples.size() == 0) begin
                error_count++;
                $display("%0t: sample_value %0d arrived with nothing pending",
                         $time, sample_ch.sample_value);
            end else begin
                oldest_sample = pending_samples.pop_front();
                if (sample_ch.sample_value !== oldest_sample.value) begin
                    error_count++;
                    $display("%0t: index %h sample_value expected %0d actual %0d",
                             $time, oldest_sample.idx, oldest_sample.value,
                             sample_ch.sample_value);
                end
            end
        end
        // long hold-off first, random stalls otherwise
        if (rx_hold_left > 0) begin
            sample_ch.ready <= 1'b0;
            rx_hold_left--;
        end else begin
            sample_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // offer one index item, optionally after random idle cycles, until accepted
    task automatic send_item(input logic [31:0] idx, input bit typed,
                             input logic signed [SAMPLE_W-1:0] typed_val);
        t_pending item;
        while ($urandom_range(99) < src_idle_pct) begin
            index_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        index_ch.valid        <= 1'b1;
        index_ch.sample_index <= idx;
        do @(posedge i_clk); while (!index_ch.ready);
        item.idx   = idx;
        item.value = typed ? typed_val : predict_sample(idx);
        pending_samples.push_back(item);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0) @(posedge i_clk);
    endtask

    // setup and access cycle, shadow updated to match
    task automatic write_reg(input int reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * reg_idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            sosc_pkg::REG_AMPLITUDE: osc_amplitude = value[15:0];
            sosc_pkg::REG_PHASE_INC: osc_phase_inc = value;
            sosc_pkg::REG_PHASE_OFF: osc_phase_off = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // mostly runs of consecutive indexes, some isolated random ones
    task automatic run_random(input int n_items);
        int          sent;
        int          run_len;
        logic [31:0] idx;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0: begin
                    idx     = $urandom;
                    run_len = 1;
                end
                1: begin
                    idx     = 32'hffff_ffff - $urandom_range(20);
                    run_len = $urandom_range(2, 40);
                end
                2: begin
                    idx     = $urandom_range(50);
                    run_len = $urandom_range(2, 40);
                end
                default: begin
                    idx     = $urandom;
                    run_len = $urandom_range(2, 40);
                end
            endcase
            for (int j = 0; j < run_len && sent < n_items; j++) begin
                send_item(idx, 1'b0, 16'sd0);
                idx  = idx + 1;
                sent = sent + 1;
            end
        end
    endtask

    // stimulus
    initial begin
        logic [31:0] cfg_amp;
        logic [31:0] cfg_inc;
        logic [31:0] cfg_off;

        i_rst_n               = 1'b0;
        index_ch.valid        = 1'b0;
        index_ch.sample_index = '0;
        sample_ch.ready       = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        error_count           = 0;
        cycle_count           = 0;
        src_idle_pct          = 0;
        snk_stall_pct         = 0;
        rx_hold_left          = 0;

        for (int j = 0; j <= TAB_STEPS; j++) begin
            quarter_wave[j] = rotate_quarter_sine(j);
        end
        osc_amplitude = 16'd32768;
        osc_phase_inc = 32'd42852281;
        osc_phase_off = 32'd0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
                index_ch.valid <= 1'b0;
                wait_drained();
                write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].val);
            end else begin
                send_item(DIRECTED_ROWS[r].val, DIRECTED_ROWS[r].kind == ROW_CHECK,
                          DIRECTED_ROWS[r].want);
            end
        end

        // random phases, new settings and idling pattern each time
        for (int p = 0; p < 8; p++) begin
            index_ch.valid <= 1'b0;
            wait_drained();
            case (p)
                0: begin
                    cfg_amp = 32'h0000_ffff;
                    cfg_inc = 32'hffff_ffff;
                    cfg_off = 32'hffff_ffff;
                end
                1: begin
                    cfg_amp = 32'h0000_0000;
                    cfg_inc = 32'h0000_0000;
                    cfg_off = 32'h0000_0000;
                end
                2: begin
                    cfg_amp = 32'h0000_8000;
                    cfg_inc = 32'd42852281;
                    cfg_off = $urandom;
                end
                default: begin
                    case ($urandom_range(4))
                        0: cfg_amp = 32'h0000_0000;
                        1: cfg_amp = 32'h0000_8000;
                        2: cfg_amp = 32'h0000_ffff;
                        default: cfg_amp = $urandom_range(16'hffff);
                    endcase
                    case ($urandom_range(5))
                        0: cfg_inc = $urandom_range(255);
                        1: cfg_inc = 32'hffff_ffff - $urandom_range(255);
                        2: cfg_inc = 32'd42852281;
                        default: cfg_inc = $urandom;
                    endcase
                    cfg_off = $urandom;
                end
            endcase
            write_reg(sosc_pkg::REG_AMPLITUDE, cfg_amp);
            write_reg(sosc_pkg::REG_PHASE_INC, cfg_inc);
            write_reg(sosc_pkg::REG_PHASE_OFF, cfg_off);
            case (p % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 55;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 55;
                end
                default: begin
                    src_idle_pct  = 16;
                    snk_stall_pct = 16;
                end
            endcase
            run_random(200);
        end

        // long receiver hold-off while items keep coming, fills the chain
        index_ch.valid <= 1'b0;
        wait_drained();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        rx_hold_left  = 400;
        run_random(150);

        index_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && pending_samples.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
